/* hw/rtl/ggeth_pkg.sv */
// Shared types, constants and helpers for the gray gradient edge threshold block.
// Used by every module under hw/rtl except ggeth_ram; depends on nothing.
package ggeth_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 4096;
    localparam int QUEUE_DEPTH    = 4;
    localparam int SIZE_MIN       = 3;

    localparam int WIDTH_RESET  = 320;
    localparam int HEIGHT_RESET = 240;

    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 17;
    localparam int IMG_WIDTH_W  = 11;
    localparam int IMG_HEIGHT_W = 13;
    localparam int THRESH_W     = 17;

    localparam int GRAY_W    = 8;
    localparam int GRAD_W    = 9;
    localparam int SQ_W      = 16;
    localparam int MAG_W     = 17;
    localparam int ROW_OUT_W = 12;
    localparam int COL_OUT_W = 10;

    localparam logic [THRESH_W-1:0] THRESHOLD_RESET = 17'd2000;
    localparam logic [7:0] EDGE_ON  = 8'd255;
    localparam logic [7:0] EDGE_OFF = 8'd0;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_IMAGE_WIDTH    = 2'd0,
        CFG_IMAGE_HEIGHT   = 2'd1,
        CFG_EDGE_THRESHOLD = 2'd2
    } cfg_index_t;

    // one interior window, classified and differenced, waiting for the back end
    typedef struct packed {
        logic signed [GRAD_W-1:0] dx;
        logic signed [GRAD_W-1:0] dy;
        logic [ROW_OUT_W-1:0]     row;
        logic [COL_OUT_W-1:0]     col;
        logic                     frame_end;
    } grad_t;

    function automatic int clamp_size(int v, int lo, int hi);
        int r;
        r = v;
        if (v < lo) r = lo;
        else if (v > hi) r = hi;
        return r;
    endfunction

    // shift-and-add luma, never above 251
    function automatic logic [GRAY_W-1:0] to_gray(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        logic [GRAY_W:0] s;
        s = 9'(r >> 2) + 9'(r >> 4) + 9'(g >> 1) + 9'(g >> 4) + 9'(b >> 3);
        return s[GRAY_W-1:0];
    endfunction

endpackage

/* hw/rtl/ggeth_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ggeth_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/ggeth_front.sv */
// Front end: pixel transfer, raster position, gray conversion, line stores and
// window classification. Pushes differenced windows into the queue.
// Depends on ggeth_pkg and ggeth_ram.
module ggeth_front #(
    parameter int MAX_WIDTH  = ggeth_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = ggeth_pkg::MAX_HEIGHT_DEF,
    parameter int QDEPTH     = ggeth_pkg::QUEUE_DEPTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]    image_width,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0]   image_height,
    input  logic                              pixel_valid,
    output logic                              pixel_ready,
    input  logic [7:0]                        red,
    input  logic [7:0]                        green,
    input  logic [7:0]                        blue,
    input  logic                              frame_start,
    input  logic [$clog2(QDEPTH+1)-1:0]       queue_count,
    output logic                              push,
    output ggeth_pkg::grad_t                  push_data
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    localparam int QCW = $clog2(QDEPTH + 1);
    localparam int GW  = ggeth_pkg::GRAY_W;

    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;

    logic          s1_valid_reg;
    logic          s1_result_reg;
    logic [GW-1:0] s1_gray_reg;
    logic [CW-1:0] s1_col_reg;
    logic [ggeth_pkg::ROW_OUT_W-1:0] s1_row_out_reg;
    logic [ggeth_pkg::COL_OUT_W-1:0] s1_col_out_reg;
    logic          s1_fe_reg;
    logic [GW-1:0] left_reg;

    logic          accept;
    logic [GW-1:0] gray;
    logic [CW-1:0] cur_col;
    logic [RW-1:0] cur_row;
    logic          has_result;
    logic          frame_end_flag;
    logic [ggeth_pkg::ROW_OUT_W-1:0] row_out;
    logic [ggeth_pkg::COL_OUT_W-1:0] col_out;
    logic [CW-1:0] rdn_addr;

    logic [2*GW-1:0] rdc_data;
    logic [GW-1:0]   rdn_data;

    assign accept = pixel_valid && pixel_ready;
    assign gray   = ggeth_pkg::to_gray(red, green, blue);

    // the window in s1 always finds a slot, so only new transfers are held off
    assign pixel_ready = ((QCW+1)'(queue_count) + (QCW+1)'(s1_valid_reg && s1_result_reg))
                         < (QCW+1)'(QDEPTH);

    always_comb
    begin
        logic [WW-1:0] c_start;
        logic [HW-1:0] r_start;
        logic [WW:0]   col_p2;
        logic [WW-1:0] col_plus;
        logic [HW-1:0] row_plus;
        logic [31:0]   row_ext;
        logic [31:0]   col_ext;

        c_start = frame_start ? '0 : WW'(col_reg);
        r_start = frame_start ? '0 : HW'(row_reg);
        if (c_start >= image_width)
        begin
            c_start = '0;
            r_start = r_start + HW'(1);
        end
        if (r_start >= image_height)
        begin
            r_start = '0;
        end
        cur_col = CW'(c_start);
        cur_row = RW'(r_start);

        col_plus = WW'(cur_col) + WW'(1);
        row_plus = HW'(cur_row) + HW'(1);
        if (col_plus >= image_width)
        begin
            col_next = '0;
            row_next = (row_plus >= image_height) ? '0 : RW'(row_plus);
        end
        else
        begin
            col_next = CW'(col_plus);
            row_next = cur_row;
        end

        col_p2         = (WW+1)'(cur_col) + (WW+1)'(2);
        has_result     = (32'(cur_row) >= 32'd2) && (cur_col != '0)
                         && (col_p2 <= (WW+1)'(image_width));
        frame_end_flag = (row_plus == image_height) && (col_p2 == (WW+1)'(image_width));

        row_ext = 32'(cur_row) - 32'd1;
        col_ext = 32'(cur_col);
        row_out = row_ext[ggeth_pkg::ROW_OUT_W-1:0];
        col_out = col_ext[ggeth_pkg::COL_OUT_W-1:0];

        // right neighbor; the last column never needs it
        if (col_ext + 32'd1 >= 32'(MAX_WIDTH))
        begin
            rdn_addr = '0;
        end
        else
        begin
            rdn_addr = CW'(col_ext + 32'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            s1_result_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            if (accept)
            begin
                col_reg       <= col_next;
                row_reg       <= row_next;
                s1_result_reg <= has_result;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_gray_reg    <= gray;
            s1_col_reg     <= cur_col;
            s1_row_out_reg <= row_out;
            s1_col_out_reg <= col_out;
            s1_fe_reg      <= frame_end_flag;
        end
        if (s1_valid_reg)
        begin
            left_reg <= rdc_data[2*GW-1:GW];
        end
    end

    // each entry holds {row above, row two above} for its column
    ggeth_ram #(
        .WIDTH (2*GW),
        .DEPTH (MAX_WIDTH)
    ) u_line_pair (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_col_reg),
        .wdata ({s1_gray_reg, rdc_data[2*GW-1:GW]}),
        .re    (accept),
        .raddr (cur_col),
        .rdata (rdc_data)
    );

    // copy of the row above, read one column ahead
    ggeth_ram #(
        .WIDTH (GW),
        .DEPTH (MAX_WIDTH)
    ) u_line_ahead (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_col_reg),
        .wdata (s1_gray_reg),
        .re    (accept),
        .raddr (rdn_addr),
        .rdata (rdn_data)
    );

    assign push = s1_valid_reg && s1_result_reg;

    always_comb
    begin
        push_data.dx        = ggeth_pkg::GRAD_W'({1'b0, rdn_data} - {1'b0, left_reg});
        push_data.dy        = ggeth_pkg::GRAD_W'({1'b0, s1_gray_reg} - {1'b0, rdc_data[GW-1:0]});
        push_data.row       = s1_row_out_reg;
        push_data.col       = s1_col_out_reg;
        push_data.frame_end = s1_fe_reg;
    end

    a_accept_reaches_s1: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted pixel did not reach the line store stage");

endmodule

/* hw/rtl/ggeth_queue.sv */
// Short FIFO of differenced windows between front and back end.
// Depends on ggeth_pkg.
module ggeth_queue #(
    parameter int DEPTH = ggeth_pkg::QUEUE_DEPTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  ggeth_pkg::grad_t             push_data,
    input  logic                         pop,
    output ggeth_pkg::grad_t             pop_data,
    output logic [$clog2(DEPTH+1)-1:0]   count,
    output logic                         not_empty
);

    localparam int PW  = $clog2(DEPTH);
    localparam int CNW = $clog2(DEPTH + 1);

    ggeth_pkg::grad_t slot_reg [DEPTH];
    logic [PW-1:0]    head_reg, head_next;
    logic [PW-1:0]    tail_reg, tail_next;
    logic [CNW-1:0]   count_reg, count_next;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (push)
        begin
            tail_next = (tail_reg == PW'(DEPTH - 1)) ? '0 : tail_reg + PW'(1);
        end
        if (pop)
        begin
            head_next = (head_reg == PW'(DEPTH - 1)) ? '0 : head_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[tail_reg] <= push_data;
        end
    end

    assign pop_data  = slot_reg[head_reg];
    assign count     = count_reg;
    assign not_empty = (count_reg != '0);

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg < CNW'(DEPTH)))
        else $error("push into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("pop from an empty queue");

endmodule

/* hw/rtl/ggeth_back.sv */
// Back end: squares the gradients, sums and compares against the threshold,
// and holds the result in an output register. Depends on ggeth_pkg.
module ggeth_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [ggeth_pkg::THRESH_W-1:0]      edge_threshold,
    input  logic                                q_not_empty,
    input  ggeth_pkg::grad_t                    q_data,
    output logic                                pop,
    output logic                                result_valid,
    input  logic                                result_ready,
    output logic [7:0]                          edge_value,
    output logic [ggeth_pkg::ROW_OUT_W-1:0]     center_row,
    output logic [ggeth_pkg::COL_OUT_W-1:0]     center_col,
    output logic                                frame_end
);

    localparam int SQ  = ggeth_pkg::SQ_W;
    localparam int MW  = ggeth_pkg::MAG_W;
    localparam int GDW = ggeth_pkg::GRAD_W;

    logic          b1_valid_reg;
    logic [SQ-1:0] b1_sqx_reg, b1_sqy_reg;
    logic [ggeth_pkg::ROW_OUT_W-1:0] b1_row_reg;
    logic [ggeth_pkg::COL_OUT_W-1:0] b1_col_reg;
    logic          b1_fe_reg;

    logic          out_valid_reg;
    logic [7:0]    out_edge_reg;
    logic [ggeth_pkg::ROW_OUT_W-1:0] out_row_reg;
    logic [ggeth_pkg::COL_OUT_W-1:0] out_col_reg;
    logic          out_fe_reg;

    logic                  out_load;
    logic                  b1_free;
    logic signed [2*GDW-1:0] prod_x, prod_y;
    logic [SQ-1:0]         sqx_next, sqy_next;
    logic [MW-1:0]         mag;
    logic [7:0]            edge_next;

    assign out_load = b1_valid_reg && (!out_valid_reg || result_ready);
    assign b1_free  = !b1_valid_reg || out_load;
    assign pop      = q_not_empty && b1_free;

    assign prod_x   = q_data.dx * q_data.dx;
    assign prod_y   = q_data.dy * q_data.dy;
    assign sqx_next = SQ'(prod_x);
    assign sqy_next = SQ'(prod_y);

    assign mag       = MW'(b1_sqx_reg) + MW'(b1_sqy_reg);
    assign edge_next = (mag > edge_threshold) ? ggeth_pkg::EDGE_ON : ggeth_pkg::EDGE_OFF;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (b1_free)
            begin
                b1_valid_reg <= pop;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            b1_sqx_reg <= sqx_next;
            b1_sqy_reg <= sqy_next;
            b1_row_reg <= q_data.row;
            b1_col_reg <= q_data.col;
            b1_fe_reg  <= q_data.frame_end;
        end
        if (out_load)
        begin
            out_edge_reg <= edge_next;
            out_row_reg  <= b1_row_reg;
            out_col_reg  <= b1_col_reg;
            out_fe_reg   <= b1_fe_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign edge_value   = out_edge_reg;
    assign center_row   = out_row_reg;
    assign center_col   = out_col_reg;
    assign frame_end    = out_fe_reg;

    a_pop_fills_b1: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> b1_valid_reg)
        else $error("popped window lost before the square stage");

    a_b1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (b1_valid_reg && !out_load) |=> (b1_valid_reg && $stable(b1_sqx_reg)
                                         && $stable(b1_row_reg)))
        else $error("square stage changed while the output was stalled");

endmodule

/* hw/rtl/gray_gradient_edge_threshold_top.sv */
// Top level of the gray gradient edge threshold block: configuration registers
// and the front end, queue and back end. Depends on ggeth_pkg and all ggeth_* modules.
//
// Usage:
//   Pixels (red, green, blue, frame_start) arrive in raster order on the
//   pixel_valid/pixel_ready channel. frame_start marks pixel (0,0) of a frame;
//   the position also wraps on its own after the last pixel of a frame.
//   For every interior window centre one result (edge_value, center_row,
//   center_col, frame_end) leaves on result_valid/result_ready; border
//   centres give nothing.
//   The result for a centre follows the transfer of the pixel below it
//   (line store read, queue, square stage, compare into the output
//   register). Throughput: one pixel per cycle while pixel_ready is high,
//   set by one line store access per pixel on each of the two line RAMs.
//   The config port (cfg_we, cfg_addr, cfg_wdata) writes image_width,
//   image_height and edge_threshold; sizes are clamped to [3, MAX_WIDTH]
//   and [3, MAX_HEIGHT]. Write only while the block is idle.
//   Reset restores 320 x 240 and threshold 2000 and puts the position at (0,0);
//   line store contents stay undefined until the first two rows are written.
//   When the receiver stalls, the output register holds and a 4-entry queue
//   absorbs windows; pixel_ready falls only once the queue is nearly full.
module gray_gradient_edge_threshold_top #(
    parameter int MAX_WIDTH  = ggeth_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = ggeth_pkg::MAX_HEIGHT_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [ggeth_pkg::CFG_INDEX_W-1:0]  cfg_addr,
    input  logic [ggeth_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                               pixel_valid,
    output logic                               pixel_ready,
    input  logic [7:0]                         red,
    input  logic [7:0]                         green,
    input  logic [7:0]                         blue,
    input  logic                               frame_start,
    output logic                               result_valid,
    input  logic                               result_ready,
    output logic [7:0]                         edge_value,
    output logic [ggeth_pkg::ROW_OUT_W-1:0]    center_row,
    output logic [ggeth_pkg::COL_OUT_W-1:0]    center_col,
    output logic                               frame_end
);

    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    localparam int QD  = ggeth_pkg::QUEUE_DEPTH;
    localparam int QCW = $clog2(QD + 1);

    localparam logic [WW-1:0] WIDTH_RST =
        WW'(ggeth_pkg::clamp_size(ggeth_pkg::WIDTH_RESET, ggeth_pkg::SIZE_MIN, MAX_WIDTH));
    localparam logic [HW-1:0] HEIGHT_RST =
        HW'(ggeth_pkg::clamp_size(ggeth_pkg::HEIGHT_RESET, ggeth_pkg::SIZE_MIN, MAX_HEIGHT));

    logic [WW-1:0] width_reg, width_next;
    logic [HW-1:0] height_reg, height_next;
    logic [ggeth_pkg::THRESH_W-1:0] threshold_reg;

    logic             q_push;
    ggeth_pkg::grad_t q_push_data;
    logic             q_pop;
    ggeth_pkg::grad_t q_pop_data;
    logic [QCW-1:0]   q_count;
    logic             q_not_empty;

    // sizes are stored already clamped
    assign width_next  = WW'(ggeth_pkg::clamp_size(int'(cfg_wdata[ggeth_pkg::IMG_WIDTH_W-1:0]),
                                                   ggeth_pkg::SIZE_MIN, MAX_WIDTH));
    assign height_next = HW'(ggeth_pkg::clamp_size(int'(cfg_wdata[ggeth_pkg::IMG_HEIGHT_W-1:0]),
                                                   ggeth_pkg::SIZE_MIN, MAX_HEIGHT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= WIDTH_RST;
            height_reg    <= HEIGHT_RST;
            threshold_reg <= ggeth_pkg::THRESHOLD_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                ggeth_pkg::CFG_IMAGE_WIDTH:    width_reg     <= width_next;
                ggeth_pkg::CFG_IMAGE_HEIGHT:   height_reg    <= height_next;
                ggeth_pkg::CFG_EDGE_THRESHOLD: threshold_reg <= cfg_wdata[ggeth_pkg::THRESH_W-1:0];
                default: ;
            endcase
        end
    end

    ggeth_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .QDEPTH     (QD)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .image_width  (width_reg),
        .image_height (height_reg),
        .pixel_valid  (pixel_valid),
        .pixel_ready  (pixel_ready),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .frame_start  (frame_start),
        .queue_count  (q_count),
        .push         (q_push),
        .push_data    (q_push_data)
    );

    ggeth_queue #(
        .DEPTH (QD)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .count     (q_count),
        .not_empty (q_not_empty)
    );

    ggeth_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .edge_threshold (threshold_reg),
        .q_not_empty    (q_not_empty),
        .q_data         (q_pop_data),
        .pop            (q_pop),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .edge_value     (edge_value),
        .center_row     (center_row),
        .center_col     (center_col),
        .frame_end      (frame_end)
    );

endmodule

/* sim/gray_gradient_edge_threshold_top_test.sv */
// Self-checking bench for gray_gradient_edge_threshold_top: streams RGB frames under
// random flow control and scores every edge result against a cycle-free pixel predictor.
// Depends on ggeth_pkg and the RTL under hw/rtl only.
module gray_gradient_edge_threshold_top_test;

    localparam int HALF_PERIOD  = 5;
    localparam int RANDOM_ITEMS = 640;
    localparam int FILL_WIDTH   = 192;
    localparam int FILL_ROWS    = 2;
    localparam int SETTLE       = 8;
    localparam int REPORT_LIMIT = 10;
    localparam int DIR_ROWS     = 25;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       frame_start;
    } pixel_t;

    typedef struct packed {
        logic [7:0]                      edge_value;
        logic [ggeth_pkg::ROW_OUT_W-1:0] center_row;
        logic [ggeth_pkg::COL_OUT_W-1:0] center_col;
        logic                            frame_end;
    } edge_result_t;

    typedef struct packed {
        pixel_t       px;
        logic         typed;
        edge_result_t want;
    } dir_row_t;

    localparam edge_result_t NO_EDGE = '0;

    logic                              clk = 1'b0;
    logic                              rst_n;
    logic                              cfg_we;
    logic [ggeth_pkg::CFG_INDEX_W-1:0] cfg_addr;
    logic [ggeth_pkg::CFG_DATA_W-1:0]  cfg_wdata;
    logic                              pixel_valid;
    logic                              pixel_ready;
    logic [7:0]                        red;
    logic [7:0]                        green;
    logic [7:0]                        blue;
    logic                              frame_start;
    logic                              result_valid;
    logic                              result_ready = 1'b0;
    logic [7:0]                        edge_value;
    logic [ggeth_pkg::ROW_OUT_W-1:0]   center_row;
    logic [ggeth_pkg::COL_OUT_W-1:0]   center_col;
    logic                              frame_end;

    // predictor copy of the registers, line stores and raster position
    logic [ggeth_pkg::IMG_WIDTH_W-1:0]  width_setting;
    logic [ggeth_pkg::IMG_HEIGHT_W-1:0] height_setting;
    logic [ggeth_pkg::THRESH_W-1:0]     threshold_setting;
    logic [ggeth_pkg::GRAY_W-1:0]       gray_above     [ggeth_pkg::MAX_WIDTH_DEF];
    logic [ggeth_pkg::GRAY_W-1:0]       gray_two_above [ggeth_pkg::MAX_WIDTH_DEF];
    int                                 next_col;
    int                                 next_row;

    edge_result_t expected_edges[$];
    int send_idle_pct;
    int recv_idle_pct;
    int pixels_sent;
    int results_seen;
    int settings_written;
    int error_count;

    gray_gradient_edge_threshold_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .pixel_valid  (pixel_valid),
        .pixel_ready  (pixel_ready),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .frame_start  (frame_start),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .edge_value   (edge_value),
        .center_row   (center_row),
        .center_col   (center_col),
        .frame_end    (frame_end)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // Advances the raster position by one pixel; returns 1 when the window centred one
    // row up is interior, with its thresholded squared gradient in res.
    function automatic bit classify_pixel(input pixel_t px, output edge_result_t res);
        int w, h, lum, r, c, dx, dy, mag;
        bit hit;
        w = width_setting;
        if (w < ggeth_pkg::SIZE_MIN) w = ggeth_pkg::SIZE_MIN;
        else if (w > ggeth_pkg::MAX_WIDTH_DEF) w = ggeth_pkg::MAX_WIDTH_DEF;
        h = height_setting;
        if (h < ggeth_pkg::SIZE_MIN) h = ggeth_pkg::SIZE_MIN;
        else if (h > ggeth_pkg::MAX_HEIGHT_DEF) h = ggeth_pkg::MAX_HEIGHT_DEF;
        lum = (px.red >> 2) + (px.red >> 4) + (px.green >> 1) + (px.green >> 4)
            + (px.blue >> 3);

        if (px.frame_start)
        begin
            next_col = 0;
            next_row = 0;
        end
        // size may have shrunk under the current position
        if (next_col >= w)
        begin
            next_col = 0;
            next_row++;
        end
        if (next_row >= h) next_row = 0;
        r = next_row;
        c = next_col;

        hit = 1'b0;
        res = NO_EDGE;
        if (r >= 2 && c >= 1 && c + 2 <= w)
        begin
            // left was already shifted down this row, right not yet
            dx = int'(gray_above[c + 1]) - int'(gray_two_above[c - 1]);
            dy = lum - int'(gray_two_above[c]);
            mag = dx * dx + dy * dy;
            res.edge_value = (mag > int'(threshold_setting)) ? ggeth_pkg::EDGE_ON
                                                             : ggeth_pkg::EDGE_OFF;
            res.center_row = ggeth_pkg::ROW_OUT_W'(r - 1);
            res.center_col = ggeth_pkg::COL_OUT_W'(c);
            res.frame_end  = (r + 1 == h) && (c + 2 == w);
            hit = 1'b1;
        end

        gray_two_above[c] = gray_above[c];
        gray_above[c] = ggeth_pkg::GRAY_W'(lum);

        next_col = c + 1;
        if (next_col >= w)
        begin
            next_col = 0;
            next_row = r + 1;
            if (next_row >= h) next_row = 0;
        end
        return hit;
    endfunction

    function automatic pixel_t random_pixel(input int tone);
        pixel_t px;
        if ($urandom_range(1) == 1)
        begin
            px.red   = 8'($urandom);
            px.green = 8'($urandom);
            px.blue  = 8'($urandom);
        end
        else
        begin
            // flat area with a little noise, gives small gradients
            px.red   = 8'(tone + $urandom_range(0, 7));
            px.green = 8'(tone + $urandom_range(0, 7));
            px.blue  = 8'(tone + $urandom_range(0, 7));
        end
        px.frame_start = 1'b0;
        return px;
    endfunction

    function automatic int pick_setting(input ggeth_pkg::cfg_index_t idx);
        int roll;
        roll = $urandom_range(0, 9);
        case (idx)
            ggeth_pkg::CFG_IMAGE_WIDTH:
                if (roll == 0) return $urandom_range(0, ggeth_pkg::SIZE_MIN - 1);
                else if (roll == 1) return $urandom_range(13, 64);
                else return $urandom_range(ggeth_pkg::SIZE_MIN, 12);
            ggeth_pkg::CFG_IMAGE_HEIGHT:
                if (roll == 0) return $urandom_range(0, ggeth_pkg::SIZE_MIN - 1);
                else if (roll == 1) return $urandom_range(ggeth_pkg::MAX_HEIGHT_DEF, 8191);
                else return $urandom_range(ggeth_pkg::SIZE_MIN, 8);
            default:
                if (roll == 0) return 0;
                else if (roll == 1) return 131071;
                else if (roll < 5) return $urandom_range(0, 131071);
                else return $urandom_range(0, 40000);
        endcase
    endfunction

    task automatic write_reg(input ggeth_pkg::cfg_index_t idx, input int value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= ggeth_pkg::CFG_DATA_W'(value);
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            ggeth_pkg::CFG_IMAGE_WIDTH:  width_setting  = ggeth_pkg::IMG_WIDTH_W'(value);
            ggeth_pkg::CFG_IMAGE_HEIGHT: height_setting = ggeth_pkg::IMG_HEIGHT_W'(value);
            default: threshold_setting = ggeth_pkg::THRESH_W'(value);
        endcase
        settings_written++;
    endtask

    // One pixel transfer; a typed row supplies its own expectation.
    task automatic send_pixel(input pixel_t px, input bit typed, input edge_result_t want);
        edge_result_t res;
        bit hit;
        if ($urandom_range(99) < send_idle_pct)
        begin
            pixel_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        pixel_valid <= 1'b1;
        red         <= px.red;
        green       <= px.green;
        blue        <= px.blue;
        frame_start <= px.frame_start;
        do @(posedge clk); while (!pixel_ready);
        hit = classify_pixel(px, res);
        if (typed) expected_edges.push_back(want);
        else if (hit) expected_edges.push_back(res);
        pixels_sent++;
    endtask

    // Block goes idle: all results back, then the pipeline is left to settle.
    task automatic drain();
        pixel_valid <= 1'b0;
        while (expected_edges.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    always @(posedge clk)
    begin : result_check
        edge_result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            results_seen++;
            if (expected_edges.size() == 0)
            begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                    $display("unexpected result: value %0d row %0d col %0d end %0b",
                             edge_value, center_row, center_col, frame_end);
            end
            else
            begin
                want = expected_edges.pop_front();
                if (edge_value !== want.edge_value || center_row !== want.center_row ||
                    center_col !== want.center_col || frame_end !== want.frame_end)
                begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                        $display({"mismatch: expected value %0d row %0d col %0d end %0b,",
                                  " got %0d %0d %0d %0b"},
                                 want.edge_value, want.center_row, want.center_col,
                                 want.frame_end, edge_value, center_row, center_col,
                                 frame_end);
                end
            end
        end
        result_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    initial
    begin : stimulus
        dir_row_t dir_table [DIR_ROWS];
        pixel_t px;
        int tone;
        int burst;
        int phase;
        int random_sent;

        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_addr    = ggeth_pkg::CFG_IMAGE_WIDTH;
        cfg_wdata   = '0;
        pixel_valid = 1'b0;
        red         = '0;
        green       = '0;
        blue        = '0;
        frame_start = 1'b0;

        width_setting     = ggeth_pkg::IMG_WIDTH_W'(ggeth_pkg::WIDTH_RESET);
        height_setting    = ggeth_pkg::IMG_HEIGHT_W'(ggeth_pkg::HEIGHT_RESET);
        threshold_setting = ggeth_pkg::THRESHOLD_RESET;
        foreach (gray_above[i])
        begin
            gray_above[i]     = '0;
            gray_two_above[i] = '0;
        end
        next_col = 0;
        next_row = 0;
        pixels_sent = 0;
        results_seen = 0;
        settings_written = 0;
        error_count = 0;
        random_sent = 0;
        send_idle_pct = 14;
        recv_idle_pct = 75;

        // 3x3 frames: one interior centre each; threshold stays at its reset value
        dir_table = '{
            // black/white frame, steepest gradient in both directions
            '{'{8'd255, 8'd255, 8'd255, 1'b1}, 1'b0, NO_EDGE},
            '{'{8'd0,   8'd0,   8'd0,   1'b0}, 1'b0, NO_EDGE},
            '{'{8'd255, 8'd255, 8'd255, 1'b0}, 1'b0, NO_EDGE},
            '{'{8'd0,   8'd0,   8'd0,   1'b0}, 1'b0, NO_EDGE},
            '{'{8'd255, 8'd255, 8'd255, 1'b0}, 1'b0, NO_EDGE},
            '{'{8'd255, 8'd255, 8'd255, 1'b0}, 1'b0, NO_EDGE},
            '{'{8'd0,   8'd0,   8'd0,   1'b0}, 1'b0, NO_EDGE},
            '{'{8'd255, 8'd255, 8'd255, 1'b0}, 1'b1,
              '{ggeth_pkg::EDGE_ON, 12'd1, 10'd1, 1'b1}},
            '{'{8'd0,   8'd0,   8'd0,   1'b0}, 1'b0, NO_EDGE},
            // flat frame entered by wrap alone, no frame_start
            '{'{8'd128, 8'd128, 8'd128, 1'b0}, 1'b0, NO_EDGE},
            '{'{8'd128, 8'd128, 8'd128, 1'b0}, 1'b0, NO_EDGE},
            '{'{8'd128, 8'd128, 8'd128, 1'b0}, 1'b0, NO_EDGE},
            '{'{8'd128, 8'd128, 8'd128, 1'b0}, 1'b0, NO_EDGE},
            '{'{8'd128, 8'd128, 8'd128, 1'b0}, 1'b0, NO_EDGE},
            '{'{8'd128, 8'd128, 8'd128, 1'b0}, 1'b0, NO_EDGE},
            '{'{8'd128, 8'd128, 8'd128, 1'b0}, 1'b0, NO_EDGE},
            '{'{8'd128, 8'd128, 8'd128, 1'b0}, 1'b1,
              '{ggeth_pkg::EDGE_OFF, 12'd1, 10'd1, 1'b1}},
            // frame_start on the last pixel of a frame restarts the raster
            '{'{8'd255, 8'd0,   8'd0,   1'b1}, 1'b0, NO_EDGE},
            '{'{8'd0,   8'd255, 8'd0,   1'b0}, 1'b0, NO_EDGE},
            '{'{8'd0,   8'd0,   8'd255, 1'b0}, 1'b0, NO_EDGE},
            '{'{8'd1,   8'd2,   8'd4,   1'b0}, 1'b0, NO_EDGE},
            '{'{8'd8,   8'd16,  8'd32,  1'b0}, 1'b0, NO_EDGE},
            '{'{8'd64,  8'd128, 8'd170, 1'b0}, 1'b0, NO_EDGE},
            '{'{8'd85,  8'd85,  8'd85,  1'b0}, 1'b0, NO_EDGE},
            '{'{8'd200, 8'd100, 8'd50,  1'b0}, 1'b0, NO_EDGE}
        };

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_reg(ggeth_pkg::CFG_IMAGE_WIDTH, ggeth_pkg::SIZE_MIN);
        write_reg(ggeth_pkg::CFG_IMAGE_HEIGHT, ggeth_pkg::SIZE_MIN);
        for (int i = 0; i < DIR_ROWS; i++)
            send_pixel(dir_table[i].px, dir_table[i].typed, dir_table[i].want);
        drain();

        // Two wide rows fill both line stores past any column the random part reaches,
        // so later size changes anywhere in a frame never read unwritten entries.
        write_reg(ggeth_pkg::CFG_IMAGE_WIDTH, FILL_WIDTH);
        write_reg(ggeth_pkg::CFG_IMAGE_HEIGHT, ggeth_pkg::SIZE_MIN);
        write_reg(ggeth_pkg::CFG_EDGE_THRESHOLD, $urandom_range(0, 60000));
        tone = $urandom_range(0, 255);
        for (int i = 0; i < FILL_ROWS * FILL_WIDTH; i++)
        begin
            px = random_pixel(tone);
            px.frame_start = (i == 0);
            send_pixel(px, 1'b0, NO_EDGE);
        end
        drain();

        phase = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            if (random_sent >= 2 * RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            else if (random_sent >= RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 75;
                recv_idle_pct = 14;
            end

            // settings may land mid-frame: covers shrink past the current position
            case (phase)
                0:
                begin
                    write_reg(ggeth_pkg::CFG_IMAGE_WIDTH, 0);
                    write_reg(ggeth_pkg::CFG_IMAGE_HEIGHT, 8191);
                    write_reg(ggeth_pkg::CFG_EDGE_THRESHOLD, 0);
                end
                1:
                begin
                    write_reg(ggeth_pkg::CFG_IMAGE_WIDTH, 1);
                    write_reg(ggeth_pkg::CFG_IMAGE_HEIGHT, 0);
                    write_reg(ggeth_pkg::CFG_EDGE_THRESHOLD, 131071);
                end
                2:
                begin
                    write_reg(ggeth_pkg::CFG_IMAGE_WIDTH, 4);
                    write_reg(ggeth_pkg::CFG_IMAGE_HEIGHT, ggeth_pkg::MAX_HEIGHT_DEF);
                    write_reg(ggeth_pkg::CFG_EDGE_THRESHOLD, 1);
                end
                3:
                begin
                    write_reg(ggeth_pkg::CFG_IMAGE_WIDTH, ggeth_pkg::MAX_WIDTH_DEF);
                    write_reg(ggeth_pkg::CFG_IMAGE_HEIGHT, ggeth_pkg::SIZE_MIN);
                end
                default:
                begin
                    if ($urandom_range(1) == 1)
                        write_reg(ggeth_pkg::CFG_IMAGE_WIDTH,
                                  pick_setting(ggeth_pkg::CFG_IMAGE_WIDTH));
                    if ($urandom_range(1) == 1)
                        write_reg(ggeth_pkg::CFG_IMAGE_HEIGHT,
                                  pick_setting(ggeth_pkg::CFG_IMAGE_HEIGHT));
                    if ($urandom_range(1) == 1)
                        write_reg(ggeth_pkg::CFG_EDGE_THRESHOLD,
                                  pick_setting(ggeth_pkg::CFG_EDGE_THRESHOLD));
                end
            endcase

            tone = $urandom_range(0, 255);
            burst = $urandom_range(40, 160);
            repeat (burst)
            begin
                px = random_pixel(tone);
                if (next_col == 0 && next_row == 0) px.frame_start = $urandom_range(1);
                else px.frame_start = ($urandom_range(0, 127) == 0);
                send_pixel(px, 1'b0, NO_EDGE);
                random_sent++;
            end
            drain();
            phase++;
        end

        $display("sent %0d pixels, checked %0d edge results, %0d register writes",
                 pixels_sent, results_seen, settings_written);
        $display("flow control: heavy result stall, heavy pixel gaps, then none");
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin : watchdog
        #(2 * HALF_PERIOD * 1_000_000);
        $display("timeout with %0d results outstanding", expected_edges.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
